[rtl/particle_pool_update_top_defines.svh]
// ----------------------------------------------------------------------------
// particle_pool_update_top_defines.svh
// Assertion macros shared by the particle pool checker.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_UPDATE_TOP_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PPU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ppu_pkg.sv]
// ----------------------------------------------------------------------------
// ppu_pkg
// Types, emitter tables and shading helpers for the particle pool.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam logic FUNC_EMIT = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_DUST       = 2'd0,
    KIND_LAND_DUST  = 2'd1,
    KIND_DISSIPATE  = 2'd2,
    KIND_EXPLOSION  = 2'd3
  } ppu_kind_t;

  localparam int MAX_REPORT = 32;
  localparam logic [9:0] FADE_Q8 = 10'd768;
  localparam logic [7:0] ALPHA_FULL = 8'd255;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EM_WR, ST_EM_LOAD, ST_TK_CHK, ST_TK_RD, ST_TK_MX, ST_TK_MY,
    ST_TK_W1, ST_TK_W2, ST_MV_RD, ST_MV_WR, ST_RP_CHK, ST_RP_RD, ST_RP_CALC,
    ST_RP_LOAD, ST_OUT
  } ppu_state_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic signed [16:0]  life;
    logic signed [15:0]  vy;
    logic signed [15:0]  vx;
    logic signed [31:0]  y;
    logic signed [31:0]  x;
  } ppu_rec_t;

  function automatic logic [1:0] kind_count(input logic [1:0] k);
    unique case (k)
      KIND_LAND_DUST: kind_count = 2'd2;
      default:        kind_count = 2'd1;
    endcase
  endfunction

  function automatic logic [12:0] kind_life(input logic [1:0] k);
    unique case (k)
      KIND_DUST, KIND_EXPLOSION: kind_life = 13'd5120;
      default:                   kind_life = 13'd2560;
    endcase
  endfunction

  function automatic logic signed [15:0] kind_vx(input logic [1:0] k, input logic even);
    unique case (k)
      KIND_LAND_DUST: kind_vx = even ? -16'sd128 : 16'sd128;
      default:        kind_vx = 16'sd0;
    endcase
  endfunction

  function automatic logic signed [15:0] kind_vy(input logic [1:0] k);
    unique case (k)
      KIND_DUST, KIND_LAND_DUST: kind_vy = -16'sd26;
      default:                   kind_vy = 16'sd0;
    endcase
  endfunction

  // base + floor(age * frames / life_max), by compare against fixed thresholds
  function automatic logic [4:0] kind_frame(input logic [1:0] k, input logic [13:0] age);
    logic [4:0] f;
    begin
      unique case (k)
        KIND_DUST, KIND_EXPLOSION: begin
          f = (k == KIND_DUST) ? 5'd8 : 5'd16;
          f = f + 5'(age >= 14'd1280) + 5'(age >= 14'd2560) + 5'(age >= 14'd3840);
        end
        KIND_LAND_DUST: begin
          f = 5'd8 + 5'(age >= 14'd640) + 5'(age >= 14'd1280) + 5'(age >= 14'd1920);
        end
        default: begin
          f = 5'd5 + 5'(age >= 14'd854) + 5'(age >= 14'd1707);
        end
      endcase
      kind_frame = f;
    end
  endfunction

endpackage

[rtl/ppu_mover.sv]
// ----------------------------------------------------------------------------
// ppu_mover
// Shared move unit: pos + floor(vel * dt / 256), saturated to 32 bits.
// Two register stages: product and position are registered, then the saturated sum.
// ----------------------------------------------------------------------------
module ppu_mover (
  input  logic               clk,
  input  logic signed [15:0] vel,
  input  logic        [15:0] dt,
  input  logic signed [31:0] pos,
  output logic signed [31:0] res
);
  logic signed [32:0] prod_r;
  logic signed [31:0] pos_r;
  logic signed [31:0] res_r;
  logic signed [33:0] sum;

  assign sum = 34'(pos_r) + 34'(prod_r >>> 8);

  always_ff @(posedge clk) begin
    prod_r <= vel * $signed({1'b0, dt});
    pos_r  <= pos;
    if (sum > 34'sd2147483647) begin
      res_r <= 32'sh7FFFFFFF;
    end else if (sum < -34'sd2147483648) begin
      res_r <= 32'sh80000000;
    end else begin
      res_r <= sum[31:0];
    end
  end

  assign res = res_r;
endmodule

[rtl/particle_pool_update_top.sv]
// Emit: one record is written per particle, then the result beat is loaded and offered.
// Tick: each live particle is read, moved in x and y and written back; a removed one
// is replaced by a move of the last entry; then each reported survivor is read, shaded
// and loaded; the record memory and the shared move unit set these steps.
// Output stalls hold the result beat; in_tready is low until the final beat.
// Reset (rst_n low, synchronous) empties the pool; record memory is not cleared.
// ----------------------------------------------------------------------------
// particle_pool_update_top
// Fixed-capacity particle pool: emit, move, expire and report particles.
// ----------------------------------------------------------------------------
module particle_pool_update_top #(
  parameter int POOL_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // spawn_x[31:0], spawn_y[63:32], time_step[79:64]
  input  logic [2:0]  in_tuser,   // func[0], emitter_kind[2:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // emitted[1:0], first_slot[6:2], out_x[38:7],
                                  // out_y[70:39], frame[75:71], alpha[83:76],
                                  // pool_count[89:84], zero pad
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // particle_valid[0]
);
  import ppu_pkg::*;

  localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam logic [LW-1:0] DEPTH_L = LW'(POOL_DEPTH);
  localparam logic [LW-1:0] REPORT_L =
    (POOL_DEPTH > MAX_REPORT) ? LW'(MAX_REPORT) : LW'(POOL_DEPTH);

  ppu_state_t state_r, state_nxt;

  logic [LW-1:0]      live_r, idx_r, num_r, start_r;
  logic [1:0]         kind_r;
  logic signed [31:0] sx_r, sy_r, newx_r;
  logic [15:0]        dt_r;
  ppu_rec_t           cur_r, rd_q_r;
  logic signed [17:0] life_r;
  logic [4:0]         frame_r;
  logic [9:0]         t_r;
  logic               full_r;

  // result register
  logic               o_pv_r, o_last_r;
  logic [1:0]         o_emit_r;
  logic [4:0]         o_slot_r, o_frame_r;
  logic signed [31:0] o_x_r, o_y_r;
  logic [7:0]         o_alpha_r;
  logic [5:0]         o_count_r;

  // record memory, one write and one registered read per cycle
  ppu_rec_t           mem_r [POOL_DEPTH];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  ppu_rec_t           mem_wdata;

  logic signed [15:0] mv_vel;
  logic signed [31:0] mv_pos, mv_res;

  logic               in_fire, out_fire;
  logic [1:0]         in_kind;
  logic [LW-1:0]      room, emit_n;
  logic [LW-1:0]      live_dec;
  logic signed [17:0] age_s;
  logic [13:0]        age;
  logic [12:0]        lmax;
  logic [9:0]         fade_v;
  logic [17:0]        scaled;
  logic [19:0]        alpha_p;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_kind  = in_tuser[2:1];
  assign live_dec = live_r - LW'(1);

  assign room   = DEPTH_L - live_r;
  assign emit_n = (room < LW'(kind_count(in_kind))) ? room : LW'(kind_count(in_kind));

  // age and fade of the record just read
  assign lmax  = kind_life(rd_q_r.kind);
  assign age_s = $signed({5'b0, lmax}) - 18'(rd_q_r.life);
  assign age   = age_s[17] ? 14'd0 : age_s[13:0];
  assign fade_v = (age < 14'(FADE_Q8)) ? age[9:0] : rd_q_r.life[9:0];
  assign scaled = {fade_v, 8'b0} - 18'(fade_v);
  // divide by 3 through the reciprocal 683/2048, exact below 765
  assign alpha_p = t_r * 10'd683;

  ppu_mover u_mover (
    .clk (clk),
    .vel (mv_vel),
    .dt  (dt_r),
    .pos (mv_pos),
    .res (mv_res)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem_r[mem_raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser[0] == FUNC_TICK) begin
            state_nxt = ST_TK_CHK;
          end else if (emit_n == '0) begin
            state_nxt = ST_EM_LOAD;
          end else begin
            state_nxt = ST_EM_WR;
          end
        end
      end
      ST_EM_WR:   state_nxt = (idx_r + LW'(1) == num_r) ? ST_EM_LOAD : ST_EM_WR;
      ST_EM_LOAD: state_nxt = ST_OUT;
      ST_TK_CHK:  state_nxt = (idx_r < live_r) ? ST_TK_RD : ST_RP_CHK;
      ST_TK_RD:   state_nxt = ST_TK_MX;
      ST_TK_MX:   state_nxt = ST_TK_MY;
      ST_TK_MY:   state_nxt = ST_TK_W1;
      ST_TK_W1:   state_nxt = ST_TK_W2;
      ST_TK_W2:   state_nxt = (life_r <= 18'sd0) ? ST_MV_RD : ST_TK_CHK;
      ST_MV_RD:   state_nxt = ST_MV_WR;
      ST_MV_WR:   state_nxt = ST_TK_CHK;
      ST_RP_CHK:  state_nxt = (live_r == '0) ? ST_OUT : ST_RP_RD;
      ST_RP_RD:   state_nxt = ST_RP_CALC;
      ST_RP_CALC: state_nxt = ST_RP_LOAD;
      ST_RP_LOAD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_fire) begin
          state_nxt = (o_pv_r && !o_last_r) ? ST_RP_RD : ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // state outputs: memory and move unit controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r[AW-1:0];
    mem_raddr = idx_r[AW-1:0];
    mem_wdata = cur_r;
    mv_vel    = cur_r.vy;
    mv_pos    = cur_r.y;
    unique case (state_r)
      ST_EM_WR: begin
        mem_we         = 1'b1;
        mem_waddr      = live_r[AW-1:0];
        mem_wdata.kind = kind_r;
        mem_wdata.life = 17'(kind_life(kind_r));
        mem_wdata.vy   = kind_vy(kind_r);
        mem_wdata.vx   = kind_vx(kind_r, ~idx_r[0]);
        mem_wdata.y    = sy_r;
        mem_wdata.x    = sx_r;
      end
      ST_TK_MX: begin
        mv_vel = rd_q_r.vx;
        mv_pos = rd_q_r.x;
      end
      ST_TK_W2: begin
        mem_we         = (life_r > 18'sd0);
        mem_wdata.life = life_r[16:0];
        mem_wdata.y    = mv_res;
        mem_wdata.x    = newx_r;
      end
      ST_MV_RD: mem_raddr = live_dec[AW-1:0];
      ST_MV_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_q_r;
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        kind_r  <= in_kind;
        sx_r    <= $signed(in_tdata[31:0]);
        sy_r    <= $signed(in_tdata[63:32]);
        dt_r    <= in_tdata[79:64];
        num_r   <= emit_n;
        start_r <= live_r;
        idx_r   <= '0;
      end
      ST_EM_WR: idx_r <= idx_r + LW'(1);
      ST_EM_LOAD: begin
        o_pv_r    <= 1'b0;
        o_last_r  <= 1'b1;
        o_emit_r  <= num_r[1:0];
        o_slot_r  <= (num_r != '0) ? 5'(start_r) : 5'd0;
        o_x_r     <= '0;
        o_y_r     <= '0;
        o_frame_r <= '0;
        o_alpha_r <= '0;
        o_count_r <= 6'(live_r);
      end
      ST_TK_MX: begin
        cur_r  <= rd_q_r;
        life_r <= 18'(rd_q_r.life) - $signed({2'b0, dt_r});
      end
      ST_TK_W1: newx_r <= mv_res;
      ST_TK_W2: begin
        if (life_r > 18'sd0) begin
          idx_r <= idx_r + LW'(1);
        end
      end
      ST_RP_CHK: begin
        // drop to an empty-tick result when nothing survived
        num_r     <= (live_r > REPORT_L) ? REPORT_L : live_r;
        idx_r     <= '0;
        o_pv_r    <= 1'b0;
        o_last_r  <= 1'b1;
        o_emit_r  <= '0;
        o_slot_r  <= '0;
        o_x_r     <= '0;
        o_y_r     <= '0;
        o_frame_r <= '0;
        o_alpha_r <= '0;
        o_count_r <= '0;
      end
      ST_RP_CALC: begin
        cur_r   <= rd_q_r;
        frame_r <= kind_frame(rd_q_r.kind, age);
        t_r     <= scaled[17:8];
        full_r  <= (age >= 14'(FADE_Q8)) &&
                   !(age > 14'(lmax - 13'(FADE_Q8)));
      end
      ST_RP_LOAD: begin
        o_pv_r    <= 1'b1;
        o_last_r  <= (idx_r + LW'(1) == num_r);
        o_emit_r  <= '0;
        o_slot_r  <= 5'(idx_r);
        o_x_r     <= cur_r.x;
        o_y_r     <= cur_r.y;
        o_frame_r <= frame_r;
        o_alpha_r <= full_r ? ALPHA_FULL : alpha_p[18:11];
        o_count_r <= 6'(live_r);
      end
      ST_OUT: begin
        if (out_fire) begin
          idx_r <= idx_r + LW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      live_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EM_WR) begin
        live_r <= live_r + LW'(1);
      end else if (state_r == ST_MV_WR) begin
        live_r <= live_dec;
      end
    end
  end

  assign out_tdata = {6'b0, o_count_r, o_alpha_r, o_frame_r, o_y_r, o_x_r,
                      o_slot_r, o_emit_r};
  assign out_tlast = o_last_r;
  assign out_tuser = o_pv_r;

endmodule

[rtl/ppu_checker.sv]
// ----------------------------------------------------------------------------
// ppu_checker
// Port-level checks on the particle pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "particle_pool_update_top_defines.svh"

module ppu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);
  `PPU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `PPU_ASSERT_IMPL(a_one_side, out_tvalid, !in_tready, "input taken while a result is pending")
  `PPU_ASSERT_IMPL(a_summary_last, out_tvalid && !out_tuser[0], out_tlast, "summary beat without tlast")
  `PPU_ASSERT_IMPL(a_emit_summary, out_tvalid && (out_tdata[1:0] != 2'd0), !out_tuser[0], "emit count on a particle beat")
  `PPU_ASSERT_NEXT(a_accept_busy, in_tvalid && in_tready, !in_tready, "input ready right after an accepted beat")
endmodule

bind particle_pool_update_top ppu_checker u_ppu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
